/* rtl/core/lsfb_pkg.sv */
// shared types and constants of the led strip frame buffer
`default_nettype none

package lsfb_pkg;

  localparam int MAX_PIXELS = 16;
  localparam int IDX_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int WORD_W     = 24;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = CFG_IDX_W'(2);

  // byte order codes, first transmitted color first
  typedef enum logic [2:0] {
    ORD_BGR = 3'd0,
    ORD_BRG = 3'd1,
    ORD_GBR = 3'd2,
    ORD_GRB = 3'd3,
    ORD_RBG = 3'd4,
    ORD_RGB = 3'd5
  } order_t;

  // command codes
  typedef enum logic [2:0] {
    KIND_SET      = 3'd0,
    KIND_FILL     = 3'd1,
    KIND_ROT_NEXT = 3'd2,
    KIND_ROT_PREV = 3'd3,
    KIND_CLEAR    = 3'd4,
    KIND_SHOW     = 3'd5
  } kind_t;

  // one accepted command, color already scaled and packed
  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        first;
    logic [7:0]        last;
    logic [WORD_W-1:0] word;
    logic              word_ok;
  } cmd_t;

  // sequencer to store
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              clr_en;
    logic [CNT_W-1:0]  clr_count;
  } mem_req_t;

  // one streamed pixel
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic [3:0]        position;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/led_strip_frame_buffer_core.sv */
// top level of the led strip frame buffer
//
// one command is taken at a clock edge where start is high and busy is low;
// the receiver cannot stall, so each shown pixel is on pixel_word,
// pixel_position and last for exactly one cycle, marked by result_valid.
// set writes its one pixel and fill each stored pixel of its range in
// turn; rotate reads each pixel in turn through the single store read
// port, then passes a drain state and a wrap-around write; show streams
// n beats back to back, busy dropping as the last beat comes out.
// clear, ignored commands and show without changes leave busy low.
// the store reads as zero after reset through per-pixel valid flags, so
// there is no clearing pass. configuration is written on its own channel
// and is always ready; write it only while the block is idle.
`default_nettype none

module led_strip_frame_buffer_core (
  input  logic                           clk,
  input  logic                           rst,
  // command beat
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     kind,
  input  logic [7:0]                     first_index,
  input  logic [7:0]                     last_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  // result beat
  output logic                           result_valid,
  output logic [23:0]                    pixel_word,
  output logic [3:0]                     pixel_position,
  output logic                           last,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import lsfb_pkg::*;

  logic [4:0]        pixel_count;
  logic [2:0]        channel_order;
  logic [7:0]        brightness;

  logic [CNT_W-1:0]  n;
  logic [7:0]        r_s, g_s, b_s;
  cmd_t              cmd;
  mem_req_t          req;
  res_t              res;
  logic [WORD_W-1:0] rd_data;
  logic              accept;

  // brightness weight over 256, zero passes the color through
  function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] w);
    logic [15:0] p;
    p = c * w;
    return (w != 8'd0) ? p[15:8] : c;
  endfunction

  // config registers; always ready, unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= 5'd1;
      channel_order <= ORD_GRB;
      brightness    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIXEL_COUNT:   pixel_count   <= cfg_data[4:0];
        CFG_CHANNEL_ORDER: channel_order <= cfg_data[2:0];
        CFG_BRIGHTNESS:    brightness    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixels in use: zero acts as one, clamp to the store depth
  always_comb begin
    if (pixel_count == 5'd0) begin
      n = CNT_W'(1);
    end else if (32'(pixel_count) > MAX_PIXELS) begin
      n = CNT_W'(MAX_PIXELS);
    end else begin
      n = CNT_W'(pixel_count);
    end
  end

  assign r_s = scale(red, brightness);
  assign g_s = scale(green, brightness);
  assign b_s = scale(blue, brightness);

  // pack in transmit order, first byte on top
  always_comb begin
    cmd.kind    = kind;
    cmd.first   = first_index;
    cmd.last    = last_index;
    cmd.word_ok = 1'b1;
    unique case (channel_order)
      ORD_BGR: cmd.word = {b_s, g_s, r_s};
      ORD_BRG: cmd.word = {b_s, r_s, g_s};
      ORD_GBR: cmd.word = {g_s, b_s, r_s};
      ORD_GRB: cmd.word = {g_s, r_s, b_s};
      ORD_RBG: cmd.word = {r_s, b_s, g_s};
      ORD_RGB: cmd.word = {r_s, g_s, b_s};
      default: begin
        // undefined order: set and fill store nothing
        cmd.word    = '0;
        cmd.word_ok = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  lsfb_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .n       (n),
    .busy    (busy),
    .req     (req),
    .rd_data (rd_data),
    .res     (res)
  );

  lsfb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign result_valid   = res.valid;
  assign pixel_word     = res.word;
  assign pixel_position = res.position;
  assign last           = res.last;

endmodule

`default_nettype wire

/* rtl/core/lsfb_store.sv */
// pixel memory with per-entry valid flags and registered read
`default_nettype none

module lsfb_store (
  input  logic                         clk,
  input  logic                         rst,
  input  lsfb_pkg::mem_req_t           req,
  output logic [lsfb_pkg::WORD_W-1:0]  rd_data
);
  import lsfb_pkg::*;

  logic [WORD_W-1:0]     mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] valid;
  logic [WORD_W-1:0]     data_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    data_q <= mem[req.rd_addr];
  end

  // entry that is not valid reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid[req.rd_addr];
      if (req.clr_en) begin
        for (int i = 0; i < MAX_PIXELS; i++) begin
          if (CNT_W'(i) < req.clr_count) begin
            valid[i] <= 1'b0;
          end
        end
      end
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

`default_nettype wire

/* rtl/core/lsfb_seq.sv */
// command sequencer: fill walk, rotate read-modify-write, show stream
`default_nettype none

module lsfb_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  lsfb_pkg::cmd_t              cmd,
  input  logic [lsfb_pkg::CNT_W-1:0]  n,
  output logic                        busy,
  output lsfb_pkg::mem_req_t          req,
  input  logic [lsfb_pkg::WORD_W-1:0] rd_data,
  output lsfb_pkg::res_t              res
);
  import lsfb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_DRAIN,
    S_ROT_FIX
  } state_t;

  state_t            state;
  kind_t             op;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] held;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  end_idx;
  logic [IDX_W-1:0]  arr_idx;
  logic              arr;
  logic              dirty;

  logic [7:0]        n8;
  logic [IDX_W-1:0]  last_ix;
  logic [7:0]        fill_end;
  logic              fill_go;

  assign n8      = 8'(n);
  assign last_ix = IDX_W'(n - CNT_W'(1));
  assign fill_end = (cmd.kind == KIND_SET) ? cmd.first :
                    ((cmd.last < n8) ? cmd.last : n8 - 8'd1);
  assign fill_go = cmd.word_ok && (cmd.first < n8) && (cmd.first <= fill_end);
  assign busy    = (state != S_IDLE);

  always_comb begin
    req           = '0;
    req.rd_addr   = idx;
    req.clr_en    = accept && (cmd.kind == KIND_CLEAR);
    req.clr_count = n;
    unique case (state)
      S_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx;
        req.wr_data = word_q;
      end
      S_READ, S_DRAIN: begin
        if (arr && (arr_idx != '0)) begin
          if (op == KIND_ROT_NEXT) begin
            req.wr_en   = 1'b1;
            req.wr_addr = arr_idx;
            req.wr_data = held;
          end else if (op == KIND_ROT_PREV) begin
            req.wr_en   = 1'b1;
            req.wr_addr = arr_idx - IDX_W'(1);
            req.wr_data = rd_data;
          end
        end
      end
      S_ROT_FIX: begin
        req.wr_en   = 1'b1;
        req.wr_addr = (op == KIND_ROT_NEXT) ? '0 : last_ix;
        req.wr_data = held;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dirty     <= 1'b1;
      arr       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      arr       <= (state == S_READ);
      arr_idx   <= idx;

      if (arr) begin
        if (op == KIND_SHOW) begin
          res.valid    <= 1'b1;
          res.word     <= rd_data;
          res.position <= 4'(arr_idx);
          res.last     <= (arr_idx == last_ix);
        end
        if (op == KIND_ROT_NEXT || (op == KIND_ROT_PREV && arr_idx == '0)) begin
          held <= rd_data;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.kind)
              KIND_SET, KIND_FILL: begin
                if (fill_go) begin
                  state   <= S_FILL;
                  op      <= kind_t'(cmd.kind);
                  idx     <= IDX_W'(cmd.first);
                  end_idx <= IDX_W'(fill_end);
                  word_q  <= cmd.word;
                  dirty   <= 1'b1;
                end
              end
              KIND_ROT_NEXT, KIND_ROT_PREV: begin
                if (n > CNT_W'(1)) begin
                  state <= S_READ;
                  op    <= kind_t'(cmd.kind);
                  idx   <= '0;
                  dirty <= 1'b1;
                end
              end
              KIND_CLEAR: dirty <= 1'b1;
              KIND_SHOW: begin
                if (dirty) begin
                  state <= S_READ;
                  op    <= KIND_SHOW;
                  idx   <= '0;
                  dirty <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          if (idx == end_idx) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_READ: begin
          if (idx == last_ix) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DRAIN: state <= (op == KIND_SHOW) ? S_IDLE : S_ROT_FIX;
        S_ROT_FIX: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lsfb_checker.sv */
// port-level checks of the show stream, bound to the top level
`default_nettype none

module lsfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_valid,
  input logic [3:0] pixel_position,
  input logic       last
);

  // a show run has no gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("show stream broke before last beat");

  // positions count up by one within a run
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> pixel_position == 4'($past(pixel_position) + 4'd1))
    else $error("pixel position did not advance");

  // a run starts at pixel zero
  a_pos_start: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> pixel_position == 4'd0)
    else $error("show run did not start at pixel zero");

  // mid-run beats only while the block is busy
  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("stream beat while idle");

endmodule

bind led_strip_frame_buffer_core lsfb_checker u_lsfb_checker (
  .clk            (clk),
  .rst            (rst),
  .busy           (busy),
  .result_valid   (result_valid),
  .pixel_position (pixel_position),
  .last           (last)
);

`default_nettype wire

/* tb/led_strip_frame_buffer_core_tb.sv */
// self-checking testbench for the led strip frame buffer core
`timescale 1ns / 100ps

module led_strip_frame_buffer_core_tb;
  import lsfb_pkg::*;

  // register index that maps to nothing
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // channel orders with no meaning
  localparam logic [2:0] ORDER_UNDEF_A = 3'd6;
  localparam logic [2:0] ORDER_UNDEF_B = 3'd7;

  // command codes with no meaning, the block must ignore them
  localparam logic [2:0] KIND_UNDEF_A = 3'd6;
  localparam logic [2:0] KIND_UNDEF_B = 3'd7;

  // longest busy stretch is a rotation of all MAX_PIXELS pixels
  localparam int SETTLE_CYCLES = 2 * MAX_PIXELS + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_CMDS    = 35;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] first;
    logic [7:0] stop;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         drain_first;   // hold this beat until every shown pixel is back
  } cmd_item_t;

  typedef struct {
    logic [23:0] word;
    logic [3:0]  position;
    logic        tail;
  } pixel_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [7:0]  first_index = '0;
  logic [7:0]  last_index = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        result_valid;
  logic [23:0] pixel_word;
  logic [3:0]  pixel_position;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  led_strip_frame_buffer_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .first_index    (first_index),
    .last_index     (last_index),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .result_valid   (result_valid),
    .pixel_word     (pixel_word),
    .pixel_position (pixel_position),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // commands waiting to be driven, and pixel beats that shows have promised
  cmd_item_t   cmd_backlog_q[$];
  pixel_beat_t shown_px_q[$];

  // shadow of the strip: stored words, change flag and register copies
  logic [23:0] frame_px [MAX_PIXELS];
  logic        frame_dirty = 1'b1;
  logic [4:0]  cfg_px_count = 5'd1;
  logic [2:0]  cfg_order = ORD_GRB;
  logic [7:0]  cfg_brightness = '0;

  bit cmd_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int kind_seen [8];

  // count 0 behaves as one pixel, anything past the store as a full strip
  function automatic int active_pixels();
    int n;
    n = int'(cfg_px_count);
    if (n == 0) n = 1;
    if (n > MAX_PIXELS) n = MAX_PIXELS;
    return n;
  endfunction

  // brightness is a weight over 256, zero leaves the level alone
  function automatic logic [7:0] scale_level(input logic [7:0] level);
    logic [15:0] prod;
    prod = level * cfg_brightness;
    return (cfg_brightness == 8'd0) ? level : prod[15:8];
  endfunction

  // returns 0 when the channel order has no meaning
  function automatic bit pack_color(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, output logic [23:0] word);
    word = '0;
    case (cfg_order)
      ORD_BGR: word = {b, g, r};
      ORD_BRG: word = {b, r, g};
      ORD_GBR: word = {g, b, r};
      ORD_GRB: word = {g, r, b};
      ORD_RBG: word = {r, b, g};
      ORD_RGB: word = {r, g, b};
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // applies one accepted command to the shadow strip, queueing shown pixels
  task automatic update_frame_model(input cmd_item_t c);
    int          n;
    logic [23:0] word;
    logic [23:0] keep;
    bit          word_ok;
    pixel_beat_t beat;
    n = active_pixels();
    word_ok = pack_color(scale_level(c.red), scale_level(c.green),
                         scale_level(c.blue), word);
    case (c.kind)
      KIND_SET: begin
        if (c.first < n && word_ok) begin
          frame_px[c.first[IDX_W-1:0]] = word;
          frame_dirty = 1'b1;
        end
      end
      KIND_FILL: begin
        if (word_ok) begin
          for (int i = c.first; i <= c.stop && i < n; i++) begin
            frame_px[i] = word;
            frame_dirty = 1'b1;
          end
        end
      end
      KIND_ROT_NEXT: begin
        if (n > 1) begin
          keep = frame_px[n-1];
          for (int i = n - 1; i > 0; i--) frame_px[i] = frame_px[i-1];
          frame_px[0] = keep;
          frame_dirty = 1'b1;
        end
      end
      KIND_ROT_PREV: begin
        if (n > 1) begin
          keep = frame_px[0];
          for (int i = 1; i < n; i++) frame_px[i-1] = frame_px[i];
          frame_px[n-1] = keep;
          frame_dirty = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < n; i++) frame_px[i] = '0;
        frame_dirty = 1'b1;
      end
      KIND_SHOW: begin
        // nothing streams unless the strip changed since the last show
        if (frame_dirty) begin
          frame_dirty = 1'b0;
          for (int i = 0; i < n; i++) begin
            beat.word = frame_px[i];
            beat.position = i[3:0];
            beat.tail = (i == n - 1);
            shown_px_q.push_back(beat);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
    if (mismatch_count < 10)
      $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, exp_v, act_v);
    mismatch_count++;
  endtask

  // sender: changes inputs on the falling edge, in bursts with gaps between
  always @(negedge clk) begin : cmd_driver
    cmd_item_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_accepted) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog_q.size() != 0 &&
                   !(cmd_backlog_q[0].drain_first && shown_px_q.size() != 0)) begin
        c = cmd_backlog_q.pop_front();
        kind        <= c.kind;
        first_index <= c.first;
        last_index  <= c.stop;
        red         <= c.red;
        green       <= c.green;
        blue        <= c.blue;
        start       <= 1'b1;
        if (burst_left == 0) begin
          // often no gap at all, sometimes a short one, rarely a long one
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 4) < 2) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(13, 40);
          else gap_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: samples on the rising edge, checks pixel beats, feeds the shadow
  always @(posedge clk) begin : strip_monitor
    pixel_beat_t exp_beat;
    cmd_item_t   c;
    bit          progress;
    progress = 1'b0;
    cmd_accepted = 1'b0;
    if (rst) begin
      for (int i = 0; i < MAX_PIXELS; i++) frame_px[i] = '0;
      frame_dirty = 1'b1;
      cfg_px_count = 5'd1;
      cfg_order = ORD_GRB;
      cfg_brightness = '0;
    end else begin
      // check before predicting: a show can be taken on its predecessor's last beat
      if (result_valid) begin
        progress = 1'b1;
        beats_checked++;
        if (shown_px_q.size() == 0) begin
          note_mismatch("pixel beat with none pending, word", '0, pixel_word);
        end else begin
          exp_beat = shown_px_q.pop_front();
          if (pixel_word !== exp_beat.word)
            note_mismatch("pixel_word", exp_beat.word, pixel_word);
          if (pixel_position !== exp_beat.position)
            note_mismatch("pixel_position", 24'(exp_beat.position), 24'(pixel_position));
          if (last !== exp_beat.tail)
            note_mismatch("last", 24'(exp_beat.tail), 24'(last));
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        cmd_accepted = 1'b1;
        c.kind = kind;
        c.first = first_index;
        c.stop = last_index;
        c.red = red;
        c.green = green;
        c.blue = blue;
        c.drain_first = 1'b0;
        kind_seen[kind]++;
        update_frame_model(c);
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        cfg_writes++;
        case (cfg_index)
          CFG_PIXEL_COUNT:   cfg_px_count = cfg_data[4:0];
          CFG_CHANNEL_ORDER: cfg_order = cfg_data[2:0];
          CFG_BRIGHTNESS:    cfg_brightness = cfg_data;
          default: ;
        endcase
      end
      // watchdog: too long without any beat on any channel
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("led_strip_frame_buffer_core verification failed");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [2:0] k, input logic [7:0] f, input logic [7:0] s,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input bit drain = 1'b0);
    cmd_item_t c;
    c.kind = k;
    c.first = f;
    c.stop = s;
    c.red = r;
    c.green = g;
    c.blue = b;
    c.drain_first = drain;
    cmd_backlog_q.push_back(c);
  endtask

  // random command; indexes mostly near the strip length, sometimes anywhere
  function automatic cmd_item_t random_cmd(input int n);
    cmd_item_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) c.kind = KIND_SET;
    else if (pick < 46) c.kind = KIND_FILL;
    else if (pick < 56) c.kind = KIND_ROT_NEXT;
    else if (pick < 66) c.kind = KIND_ROT_PREV;
    else if (pick < 71) c.kind = KIND_CLEAR;
    else if (pick < 95) c.kind = KIND_SHOW;
    else c.kind = $urandom_range(0, 1) ? KIND_UNDEF_A : KIND_UNDEF_B;
    c.first = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, n));
    c.stop = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                            : c.first + $urandom_range(0, n));
    c.red = 8'($urandom_range(0, 255));
    c.green = 8'($urandom_range(0, 255));
    c.blue = 8'($urandom_range(0, 255));
    c.drain_first = ($urandom_range(0, 29) == 0);
    return c;
  endfunction

  // block idle: backlog driven, all pixels back, then a settle pause
  task automatic wait_idle();
    while (cmd_backlog_q.size() != 0 || start || shown_px_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [2:0] order;
    logic [4:0] count;
    int         n;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, one pixel: reset leaves the strip marked changed
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);            // unchanged, silent
    push_cmd(KIND_SET, 8'd0, 8'd0, 8'hff, 8'h00, 8'h80);
    push_cmd(KIND_SET, 8'd1, 8'd0, 8'h11, 8'h22, 8'h33);          // beyond count
    push_cmd(KIND_ROT_NEXT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);        // single pixel, no-op
    push_cmd(KIND_UNDEF_A, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // full strip, rgb order, no scaling
    write_reg(CFG_PIXEL_COUNT, 8'd16);
    write_reg(CFG_CHANNEL_ORDER, {5'd0, ORD_RGB});
    write_reg(CFG_BRIGHTNESS, 8'd0);
    push_cmd(KIND_FILL, 8'd0, 8'd255, 8'hff, 8'h00, 8'haa);        // clipped to count
    push_cmd(KIND_SET, 8'd15, 8'd0, 8'h12, 8'h34, 8'h56);
    push_cmd(KIND_SET, 8'd16, 8'd0, 8'h01, 8'h01, 8'h01);
    push_cmd(KIND_SET, 8'd255, 8'd255, 8'h02, 8'h02, 8'h02);
    push_cmd(KIND_FILL, 8'd10, 8'd3, 8'h77, 8'h77, 8'h77);        // empty range
    push_cmd(KIND_FILL, 8'd14, 8'd200, 8'h01, 8'h02, 8'h03);
    push_cmd(KIND_ROT_NEXT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_ROT_PREV, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);  // after the stream
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // count 0 acts as one pixel; undefined orders store nothing, flag untouched
    write_reg(CFG_PIXEL_COUNT, 8'd0);
    write_reg(CFG_CHANNEL_ORDER, {5'd0, ORDER_UNDEF_A});
    write_reg(CFG_BRIGHTNESS, 8'd1);
    push_cmd(KIND_SET, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    push_cmd(KIND_FILL, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    wait_idle();
    write_reg(CFG_CHANNEL_ORDER, {5'b11111, ORDER_UNDEF_B});
    push_cmd(KIND_SET, 8'd0, 8'd0, 8'h80, 8'h80, 8'h80);
    push_cmd(KIND_UNDEF_B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // count past the store clamps to a full strip; full brightness
    write_reg(CFG_PIXEL_COUNT, 8'hff);
    write_reg(CFG_CHANNEL_ORDER, {5'd0, ORD_BGR});
    write_reg(CFG_BRIGHTNESS, 8'd255);
    write_reg(REG_UNMAPPED, 8'hff);
    push_cmd(KIND_FILL, 8'd0, 8'd255, 8'hff, 8'h80, 8'h01);
    push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // random phases, each under fresh settings written while idle
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) count = 5'd1;
      else if (p == 1) count = 5'd16;
      else if ($urandom_range(0, 5) == 0) count = 5'($urandom_range(0, 31));
      else count = 5'($urandom_range(2, 15));
      if (p < 6) order = 3'(p);
      else order = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
      write_reg(CFG_PIXEL_COUNT, {3'($urandom_range(0, 7)), count});
      write_reg(CFG_CHANNEL_ORDER, {5'($urandom_range(0, 31)), order});
      if (p == 0) write_reg(CFG_BRIGHTNESS, 8'd0);
      else if (p == 1) write_reg(CFG_BRIGHTNESS, 8'd255);
      else if ($urandom_range(0, 2) == 0) write_reg(CFG_BRIGHTNESS, 8'd0);
      else write_reg(CFG_BRIGHTNESS, 8'($urandom_range(1, 255)));
      n = active_pixels();
      for (int i = 0; i < PHASE_CMDS; i++) cmd_backlog_q.push_back(random_cmd(n));
      push_cmd(KIND_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      wait_idle();
    end

    if (shown_px_q.size() != 0) begin
      $display("%0d pixel beats never arrived", shown_px_q.size());
      mismatch_count++;
    end
    $display("covered %0d pixel beats and %0d register writes, %0d mismatches",
             beats_checked, cfg_writes, mismatch_count);
    $display("commands: set %0d fill %0d rotate %0d/%0d clear %0d show %0d unknown %0d",
             kind_seen[KIND_SET], kind_seen[KIND_FILL], kind_seen[KIND_ROT_NEXT],
             kind_seen[KIND_ROT_PREV], kind_seen[KIND_CLEAR], kind_seen[KIND_SHOW],
             kind_seen[KIND_UNDEF_A] + kind_seen[KIND_UNDEF_B]);
    if (mismatch_count == 0)
      $display("led_strip_frame_buffer_core verification clean");
    else
      $display("led_strip_frame_buffer_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lsfb_pkg.sv
rtl/core/lsfb_store.sv
rtl/core/lsfb_seq.sv
rtl/core/led_strip_frame_buffer_core.sv
rtl/core/lsfb_checker.sv
tb/led_strip_frame_buffer_core_tb.sv
